>>> sv/utxrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utxrb_pkg - shared definitions for the UART transmit ring buffer
// Queue geometry, action and interrupt codes, types and pointer helpers.
// ----------------------------------------------------------------------------
package utxrb_pkg;

    // Queue geometry: DEPTH slots, one always kept empty.
    localparam int DEPTH  = 64;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = PTR_W + 1;
    localparam int FILL_W = 6;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 2;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [2:0]        t_cause;

    // Action codes
    localparam t_action ACT_PUSH = 2'd0;
    localparam t_action ACT_KICK = 2'd1;
    localparam t_action ACT_INTR = 2'd2;

    // Interrupt identification fields
    localparam int     IIR_NONE_BIT = 0;
    localparam t_cause CAUSE_LINE   = 3'd3;
    localparam t_cause CAUSE_TX     = 3'd1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic commit;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic send;
    } t_dp_sts;

    function automatic t_ptr ptr_advance(t_ptr p);
        t_ptr r;
        r = (p == t_ptr'(DEPTH - 1)) ? '0 : p + t_ptr'(1);
        return r;
    endfunction

    function automatic t_cnt ptr_count(t_ptr wr, t_ptr rd);
        t_cnt c;
        if (wr >= rd) begin
            c = t_cnt'(wr) - t_cnt'(rd);
        end else begin
            c = t_cnt'(wr) + t_cnt'(DEPTH) - t_cnt'(rd);
        end
        return c;
    endfunction

endpackage

>>> sv/utxrb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utxrb_if - valid/ready channels of the UART transmit ring buffer
// Input channel carries one action, output channel one result per action.
// ----------------------------------------------------------------------------
interface utxrb_in_if;
    logic                 valid;
    logic                 ready;
    utxrb_pkg::t_action   action;
    utxrb_pkg::t_byte     data_byte;
    utxrb_pkg::t_byte     iir_value;
    logic                 thr_empty;

    modport source (output valid, action, data_byte, iir_value, thr_empty, input ready);
    modport sink   (input valid, action, data_byte, iir_value, thr_empty, output ready);
endinterface

interface utxrb_out_if;
    logic                 valid;
    logic                 ready;
    logic                 tx_valid;
    utxrb_pkg::t_byte     tx_byte;
    logic                 lsr_read;
    logic                 dropped;
    utxrb_pkg::t_fill     fill_level;

    modport source (output valid, tx_valid, tx_byte, lsr_read, dropped, fill_level,
                    input ready);
    modport sink   (input valid, tx_valid, tx_byte, lsr_read, dropped, fill_level,
                    output ready);
endinterface

>>> sv/utxrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utxrb_ctrl - transaction controller
// Handles both handshakes and, on a send, waits in ST_READ for store read data.
// ----------------------------------------------------------------------------
module utxrb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  utxrb_pkg::t_dp_sts i_sts,
    output utxrb_pkg::t_dp_cmd o_cmd
);

    utxrb_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              w_accept;
    logic              w_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= utxrb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_taken = r_out_valid && i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        w_accept    = 1'b0;
        case (r_state)
            utxrb_pkg::ST_IDLE: begin
                // result register free, or drained at this edge
                o_in_ready = !r_out_valid || i_out_ready;
                w_accept   = i_in_valid && o_in_ready;
                if (w_accept) begin
                    if (i_sts.send) begin
                        n_state = utxrb_pkg::ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            utxrb_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_state     = utxrb_pkg::ST_IDLE;
            end
            default: begin
                n_state = utxrb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_cmd.commit = w_accept;
    assign o_out_valid  = r_out_valid;

`ifndef SYNTHESIS
    a_send_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.send) |=> (r_state == utxrb_pkg::ST_READ) && !r_out_valid)
        else $error("send transaction did not wait for read data");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == utxrb_pkg::ST_READ) |=> r_out_valid && (r_state == utxrb_pkg::ST_IDLE))
        else $error("read cycle did not present a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !w_taken) |-> !w_accept)
        else $error("accepted a transaction over a pending result");
`endif

endmodule

>>> sv/utxrb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utxrb_dp - ring buffer datapath
// Byte store, pointers, idle flag, action decode and result register.
// ----------------------------------------------------------------------------
module utxrb_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utxrb_pkg::t_dp_cmd i_cmd,
    output utxrb_pkg::t_dp_sts o_sts,
    input  utxrb_pkg::t_action i_action,
    input  utxrb_pkg::t_byte   i_data_byte,
    input  utxrb_pkg::t_byte   i_iir_value,
    input  logic               i_thr_empty,
    output logic               o_tx_valid,
    output utxrb_pkg::t_byte   o_tx_byte,
    output logic               o_lsr_read,
    output logic               o_dropped,
    output utxrb_pkg::t_fill   o_fill_level
);

    utxrb_pkg::t_byte mem [utxrb_pkg::DEPTH];

    utxrb_pkg::t_ptr  r_rd_ptr, n_rd_ptr;
    utxrb_pkg::t_ptr  r_wr_ptr, n_wr_ptr;
    logic             r_tx_idle, n_tx_idle;
    utxrb_pkg::t_byte r_rdata;
    logic             r_tx_valid, r_lsr, r_drop;
    utxrb_pkg::t_fill r_fill;

    utxrb_pkg::t_cause w_cause;
    logic              w_irq, w_tx_irq, w_line_irq;
    logic              w_attempt, w_empty, w_full, w_send, w_push, w_drop;

    // decode
    always_comb begin
        w_cause    = i_iir_value[3:1];
        w_irq      = (i_action == utxrb_pkg::ACT_INTR)
                     && !i_iir_value[utxrb_pkg::IIR_NONE_BIT];
        w_tx_irq   = w_irq && (w_cause == utxrb_pkg::CAUSE_TX);
        w_line_irq = w_irq && (w_cause == utxrb_pkg::CAUSE_LINE);
        w_attempt  = (i_action == utxrb_pkg::ACT_KICK) || w_tx_irq;
        w_empty    = (r_rd_ptr == r_wr_ptr);
        w_full     = utxrb_pkg::ptr_count(r_wr_ptr, r_rd_ptr)
                     >= utxrb_pkg::t_cnt'(utxrb_pkg::DEPTH - 1);
        w_send     = w_attempt && !w_empty && (r_tx_idle || i_thr_empty || w_tx_irq);
        w_push     = (i_action == utxrb_pkg::ACT_PUSH) && !w_full;
        w_drop     = (i_action == utxrb_pkg::ACT_PUSH) && w_full;

        n_wr_ptr  = w_push ? utxrb_pkg::ptr_advance(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr  = w_send ? utxrb_pkg::ptr_advance(r_rd_ptr) : r_rd_ptr;
        n_tx_idle = w_send ? 1'b0 : (w_tx_irq ? 1'b1 : r_tx_idle);
    end

    assign o_sts.send = w_send;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_tx_idle <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_tx_idle <= n_tx_idle;
        end
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_push) begin
            mem[r_wr_ptr] <= i_data_byte;
        end
        if (i_cmd.commit && w_send) begin
            r_rdata <= mem[r_rd_ptr];
        end
    end

    // result fields; read data is held until the next commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_tx_valid <= w_send;
            r_lsr      <= w_line_irq;
            r_drop     <= w_drop;
            r_fill     <= utxrb_pkg::t_fill'(utxrb_pkg::ptr_count(n_wr_ptr, n_rd_ptr));
        end
    end

    assign o_tx_valid   = r_tx_valid;
    assign o_tx_byte    = r_tx_valid ? r_rdata : '0;
    assign o_lsr_read   = r_lsr;
    assign o_dropped    = r_drop;
    assign o_fill_level = r_fill;

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr <= utxrb_pkg::t_ptr'(utxrb_pkg::DEPTH - 1))
        && (r_wr_ptr <= utxrb_pkg::t_ptr'(utxrb_pkg::DEPTH - 1)))
        else $error("pointer out of range");

    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_drop) |=> $stable(r_wr_ptr))
        else $error("dropped byte moved the write pointer");

    a_send_clears_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_send) |=> !r_tx_idle && (r_rd_ptr != $past(r_rd_ptr)))
        else $error("send did not pop or clear idle");
`endif

endmodule

>>> sv/uart_tx_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_ring_buffer - UART transmit queue
// Circular byte queue with push, kick and interrupt handling.
// ----------------------------------------------------------------------------
// Usage:
//  - i_item carries one action per transaction: push a byte, kick a send
//    after a write call, or an interrupt with its identification value.
//  - o_result returns exactly one result per action: the byte written to the
//    transmit register (if any), the LSR read strobe, the drop flag and the
//    fill level after the action.
//  - A result is registered at acceptance; when the action sends a byte, it
//    follows the read state instead (the byte store read port is registered).
//  - Throughput: 1 action per cycle while no byte is sent and the receiver
//    takes each result; a sending action holds off new actions in the read state.
//  - The queue holds DEPTH-1 bytes; a push into a full queue is discarded
//    and flagged.
//  - Reset empties the queue (pointers to zero) and clears the idle flag.
//    The byte store is not cleared; only written entries are ever read.
//  - When the receiver stalls, the result register holds its transaction and
//    no new action is accepted until the result is taken (an action may be
//    accepted in the same cycle the pending result is taken).
// ----------------------------------------------------------------------------
module uart_tx_ring_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utxrb_in_if.sink    i_item,
    utxrb_out_if.source o_result
);

    utxrb_pkg::t_dp_cmd w_cmd;
    utxrb_pkg::t_dp_sts w_sts;

    // Handshake control and the wait state for read data
    utxrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Queue storage, pointers and result fields
    utxrb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_action     (i_item.action),
        .i_data_byte  (i_item.data_byte),
        .i_iir_value  (i_item.iir_value),
        .i_thr_empty  (i_item.thr_empty),
        .o_tx_valid   (o_result.tx_valid),
        .o_tx_byte    (o_result.tx_byte),
        .o_lsr_read   (o_result.lsr_read),
        .o_dropped    (o_result.dropped),
        .o_fill_level (o_result.fill_level)
    );

endmodule
